### src/arm_forward_kinematics_core_macros.svh
// Assertion macros shared by the arm forward kinematics modules.
`ifndef ARM_FORWARD_KINEMATICS_CORE_MACROS_SVH
`define ARM_FORWARD_KINEMATICS_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AFK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define AFK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/afk_pkg.sv
// Package with types, constants and the arctangent table of the arm kinematics core.
`default_nettype none
package afk_pkg;
  localparam int JointCount  = 5;
  localparam int InJoints    = 5;
  localparam int CordicSteps = 16;
  localparam int AngW        = 20;
  localparam int CsW         = 18;
  localparam int PosW        = 40;
  localparam int OutW        = 20;
  localparam int CellCount   = JointCount * CordicSteps + 2 * JointCount;
  localparam logic signed [AngW-1:0] PiQ16     = AngW'(205887);
  localparam logic signed [AngW-1:0] HalfPiQ16 = AngW'(102944);
  localparam logic signed [CsW-1:0]  CordicX0  = CsW'(39797);

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_Z_ALT = 2'd3
  } axis_t;

  typedef enum logic [2:0] {
    REG_BASE_LIFT = 3'd0,
    REG_LINK0     = 3'd1,
    REG_LINK1     = 3'd2,
    REG_LINK2     = 3'd3,
    REG_LINK3     = 3'd4,
    REG_TOOL      = 3'd5,
    REG_AXES      = 3'd6
  } reg_idx_t;

  typedef logic signed [15:0] ang_in_t;
  typedef logic signed [PosW-1:0] pos_t;

  // One beat travelling down the chain: position, remaining angles, live CORDIC.
  typedef struct packed {
    logic                        vld;
    pos_t                        px;
    pos_t                        py;
    pos_t                        pz;
    logic signed [CsW-1:0]       cx;
    logic signed [CsW-1:0]       cy;
    logic signed [AngW-1:0]      cz;
    logic                        neg;
    logic [JointCount-1:0][15:0] ang;
  } beat_t;

  function automatic logic signed [AngW-1:0] atan_q16(input logic [3:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      4'd0: r = AngW'(51472);
      4'd1: r = AngW'(30386);
      4'd2: r = AngW'(16055);
      4'd3: r = AngW'(8150);
      4'd4: r = AngW'(4091);
      4'd5: r = AngW'(2047);
      4'd6: r = AngW'(1024);
      4'd7: r = AngW'(512);
      4'd8: r = AngW'(256);
      4'd9: r = AngW'(128);
      4'd10: r = AngW'(64);
      4'd11: r = AngW'(32);
      4'd12: r = AngW'(16);
      4'd13: r = AngW'(8);
      4'd14: r = AngW'(4);
      default: r = AngW'(2);
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### src/afk_cordic_cell.sv
// One CORDIC micro-rotation cell; the step index is fixed by the instance.
`default_nettype none
module afk_cordic_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [3:0]    step,
  input  wire afk_pkg::beat_t din,
  output afk_pkg::beat_t     dout
);
  import afk_pkg::*;
  beat_t dout_r, dout_nxt;
  logic signed [CsW-1:0] xs, ys;

  always_comb begin
    xs = din.cx >>> step;
    ys = din.cy >>> step;
    dout_nxt = din;
    if (!din.cz[AngW-1]) begin
      dout_nxt.cx = din.cx - ys;
      dout_nxt.cy = din.cy + xs;
      dout_nxt.cz = din.cz - atan_q16(step);
    end else begin
      dout_nxt.cx = din.cx + ys;
      dout_nxt.cy = din.cy - xs;
      dout_nxt.cz = din.cz + atan_q16(step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r <= '0;
    end else begin
      dout_r <= dout_nxt;
    end
  end
  assign dout = dout_r;
endmodule
`default_nettype wire

### src/afk_joint_cell.sv
// Joint cells: angle fold ahead of CORDIC, and the rotate that follows it.
`default_nettype none
module afk_joint_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            is_rot,
  input  wire logic [2:0]      joint,
  input  wire logic [15:0]     link_add,
  input  wire logic [1:0]      axis,
  input  wire afk_pkg::beat_t  din,
  output afk_pkg::beat_t       dout
);
  import afk_pkg::*;
  beat_t dout_r, dout_nxt;
  logic signed [AngW-1:0] z;
  logic signed [CsW-1:0] c, s;
  logic signed [PosW-1:0] a0, b0, a, b;
  logic signed [PosW+CsW:0] sa, sb;

  function automatic logic signed [PosW-1:0] rnd(input logic signed [PosW+CsW:0] v);
    logic signed [PosW+CsW:0] t;
    t = v + (PosW+CsW+1)'(32768);
    return PosW'(t >>> 16);
  endfunction

  always_comb begin
    dout_nxt = din;
    z = AngW'($signed(din.ang[joint])) <<< 3;
    c = din.neg ? -din.cx : din.cx;
    s = din.neg ? -din.cy : din.cy;
    a0 = '0; b0 = '0; sa = '0; sb = '0; a = '0; b = '0;
    if (!is_rot) begin
      // Fold into [-pi/2, pi/2] and load the CORDIC start vector.
      dout_nxt.cx = CordicX0;
      dout_nxt.cy = '0;
      dout_nxt.neg = 1'b0;
      dout_nxt.cz = z;
      if (z > HalfPiQ16) begin
        dout_nxt.cz = z - PiQ16; dout_nxt.neg = 1'b1;
      end else if (z < -HalfPiQ16) begin
        dout_nxt.cz = z + PiQ16; dout_nxt.neg = 1'b1;
      end
    end else begin
      unique case (axis_t'(axis))
        AXIS_X: begin a0 = din.py; b0 = din.pz; end
        AXIS_Y: begin a0 = din.px; b0 = din.pz; end
        default: begin a0 = din.px; b0 = din.py; end
      endcase
      sa = $signed(c) * a0 - $signed(s) * b0;
      sb = $signed(s) * a0 + $signed(c) * b0;
      if (axis_t'(axis) == AXIS_Y) begin
        sa = $signed(c) * a0 + $signed(s) * b0;
        sb = $signed(c) * b0 - $signed(s) * a0;
      end
      a = rnd(sa);
      b = rnd(sb);
      unique case (axis_t'(axis))
        AXIS_X: begin dout_nxt.py = a; dout_nxt.pz = b; end
        AXIS_Y: begin dout_nxt.px = a; dout_nxt.pz = b; end
        default: begin dout_nxt.px = a; dout_nxt.py = b; end
      endcase
      dout_nxt.pz = dout_nxt.pz + PosW'(link_add);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r <= '0;
    end else begin
      dout_r <= dout_nxt;
    end
  end
  assign dout = dout_r;
endmodule
`default_nettype wire

### src/arm_forward_kinematics_core.sv
// Top level of the arm forward kinematics core: config registers and the cell chain.
// One pose can enter every cycle (busy stays low). Its tip position is on the out_
// ports, marked by out_valid, once the pose has passed the chain of sixteen CORDIC
// cells plus fold and rotate cells per joint, and one output register. The
// receiver cannot stall, so every result beat must be taken in the cycle out_valid
// is high.
`default_nettype none
module arm_forward_kinematics_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [15:0] in_joint0_angle,
  input  wire logic signed [15:0] in_joint1_angle,
  input  wire logic signed [15:0] in_joint2_angle,
  input  wire logic signed [15:0] in_joint3_angle,
  input  wire logic signed [15:0] in_joint4_angle,
  output logic             out_valid,
  output logic signed [19:0] out_tip_x,
  output logic signed [19:0] out_tip_y,
  output logic signed [19:0] out_tip_z,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import afk_pkg::*;
  `include "arm_forward_kinematics_core_macros.svh"

  logic [15:0] base_r, tool_r;
  logic [3:0][15:0] link_r;
  logic [9:0] axes_r;
  beat_t chain [0:CellCount];
  beat_t head;
  logic out_valid_r;
  logic signed [OutW-1:0] ox_r, oy_r, oz_r;
  logic signed [PosW-1:0] zf;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 16'd4915; link_r[0] <= 16'd3342; link_r[1] <= 16'd14746;
      link_r[2] <= 16'd13107; link_r[3] <= 16'd5243; tool_r <= 16'd7274;
      axes_r <= 10'd598;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE_LIFT: base_r <= cfg_data;
        REG_LINK0: link_r[0] <= cfg_data;
        REG_LINK1: link_r[1] <= cfg_data;
        REG_LINK2: link_r[2] <= cfg_data;
        REG_LINK3: link_r[3] <= cfg_data;
        REG_TOOL: tool_r <= cfg_data;
        REG_AXES: axes_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    head = '0;
    head.vld = start;
    head.pz = PosW'(tool_r);
    head.ang[0] = in_joint0_angle;
    head.ang[1] = in_joint1_angle;
    head.ang[2] = in_joint2_angle;
    head.ang[3] = in_joint3_angle;
    head.ang[4] = in_joint4_angle;
  end
  assign chain[0] = head;

  // Joints run from the last down to 0; each has fold, 16 steps, rotate.
  for (genvar j = 0; j < JointCount; j++) begin : g_joint
    localparam int Jk = JointCount - 1 - j;
    localparam int B = j * (CordicSteps + 2);
    logic [15:0] ladd;
    logic [1:0] ax;
    assign ladd = (Jk >= 1 && Jk <= 4) ? link_r[(Jk >= 1 ? Jk : 1) - 1] : 16'd0;
    assign ax = (Jk < InJoints) ? axes_r[2*(Jk < InJoints ? Jk : 0) +: 2] : AXIS_Z;
    afk_joint_cell u_fold (.clk, .rst_n, .is_rot(1'b0), .joint(3'(Jk)),
      .link_add(16'd0), .axis(ax), .din(chain[B]), .dout(chain[B+1]));
    for (genvar i = 0; i < CordicSteps; i++) begin : g_step
      afk_cordic_cell u_step (.clk, .rst_n, .step(4'(i)),
        .din(chain[B+1+i]), .dout(chain[B+2+i]));
    end
    // The link after the next lower joint is added right after this rotation.
    afk_joint_cell u_rot (.clk, .rst_n, .is_rot(1'b1), .joint(3'(Jk)),
      .link_add(ladd), .axis(ax), .din(chain[B+1+CordicSteps]),
      .dout(chain[B+2+CordicSteps]));
  end

  function automatic logic signed [OutW-1:0] sat(input logic signed [PosW-1:0] v);
    if (v > PosW'(524287)) return OutW'(524287);
    if (v < -PosW'(524288)) return OutW'(-524288);
    return OutW'(v);
  endfunction

  assign zf = chain[CellCount].pz + PosW'(base_r);
  always_ff @(posedge clk) begin
    ox_r <= sat(chain[CellCount].px);
    oy_r <= sat(chain[CellCount].py);
    oz_r <= sat(zf);
    out_valid_r <= rst_n & chain[CellCount].vld;
  end
  assign out_valid = out_valid_r;
  assign out_tip_x = ox_r;
  assign out_tip_y = oy_r;
  assign out_tip_z = oz_r;

  `AFK_ASSERT_IMP(a_busy_low, clk, rst_n, 1'b1, !busy, "busy must stay low")
  `AFK_ASSERT_NXT(a_out_from_chain, clk, rst_n, chain[CellCount].vld, out_valid,
    "chain exit must produce a result beat")
  `AFK_ASSERT_NXT(a_no_spurious, clk, rst_n, !chain[CellCount].vld, !out_valid,
    "result beat without chain exit")
endmodule
`default_nettype wire
